[hw/rtl/mxfp4_block_dot_accumulate_defines.svh]
// assertion macros shared by the mxfp4 block dot accumulate rtl
// needs i_clk and i_rst_n in the scope of the module that uses them
`ifndef MXFP4_BLOCK_DOT_ACCUMULATE_DEFINES_SVH
`define MXFP4_BLOCK_DOT_ACCUMULATE_DEFINES_SVH

// same-cycle implication
`define MBDA_ASSERT_SAME(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("%m: check failed");

// next-cycle implication
`define MBDA_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("%m: check failed");

`endif

[hw/rtl/mbda_pkg.sv]
// shared constants and the e2m1 code table for the mxfp4 block dot accumulate
// no dependencies
package mbda_pkg;

    localparam int LANES      = 4;
    localparam int LANE_COLS  = 8;
    localparam int CODE_W     = 4;
    localparam int ACT_W      = 8;
    localparam int LANE_SUM_W = 15;
    localparam int DOT_W      = 17;

    localparam logic [31:0] FP32_ZERO      = 32'h0000_0000;
    localparam logic [31:0] FP32_HALF      = 32'h3F00_0000;
    localparam logic [31:0] FP32_CANON_NAN = 32'h7FC0_0000;
    localparam logic [31:0] FP32_MIN_SCALE = 32'h0040_0000;
    localparam logic [7:0]  EXP_ALL_ONES   = 8'hFF;

    // doubled e2m1 value, bit 3 is the sign
    function automatic logic signed [4:0] code_value(input logic [CODE_W-1:0] code);
        logic [4:0] mag;
        case (code[2:0])
            3'd0:    mag = 5'd0;
            3'd1:    mag = 5'd1;
            3'd2:    mag = 5'd2;
            3'd3:    mag = 5'd3;
            3'd4:    mag = 5'd4;
            3'd5:    mag = 5'd6;
            3'd6:    mag = 5'd8;
            3'd7:    mag = 5'd12;
            default: mag = 5'd0;
        endcase
        return code[3] ? $signed(-mag) : $signed(mag);
    endfunction

endpackage

[hw/rtl/mbda_lane.sv]
// one lane: exact integer dot product of eight doubled e2m1 weights with eight int8 activations
// uses mbda_pkg
module mbda_lane (
    input  logic [mbda_pkg::LANE_COLS*mbda_pkg::CODE_W-1:0] i_codes,
    input  logic [mbda_pkg::LANE_COLS*mbda_pkg::ACT_W-1:0]  i_acts,
    output logic signed [mbda_pkg::LANE_SUM_W-1:0]          o_sum
);

    logic signed [12:0] w_prod [mbda_pkg::LANE_COLS];

    always_comb begin
        o_sum = '0;
        for (int k = 0; k < mbda_pkg::LANE_COLS; k++) begin
            w_prod[k] = 13'(mbda_pkg::code_value(i_codes[k*mbda_pkg::CODE_W +: mbda_pkg::CODE_W])
                        * $signed(i_acts[k*mbda_pkg::ACT_W +: mbda_pkg::ACT_W]));
            o_sum = o_sum + mbda_pkg::LANE_SUM_W'(w_prod[k]);
        end
    end

endmodule

[hw/rtl/mbda_fmul.sv]
// two-stage fp32 multiplier, round to nearest even, subnormals kept
// stage one multiplies the significands, stage two normalizes and rounds
module mbda_fmul (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_y
);

    logic [7:0]         w_ea, w_eb;
    logic [23:0]        w_ma, w_mb;
    logic               w_a_nan, w_b_nan, w_a_inf, w_b_inf, w_a_zero, w_b_zero;

    logic [47:0]        r_p;
    logic signed [10:0] r_e;
    logic               r_sign, r_nan, r_inf, r_zero;

    always_comb begin
        w_ea     = (i_a[30:23] == 8'd0) ? 8'd1 : i_a[30:23];
        w_eb     = (i_b[30:23] == 8'd0) ? 8'd1 : i_b[30:23];
        w_ma     = {|i_a[30:23], i_a[22:0]};
        w_mb     = {|i_b[30:23], i_b[22:0]};
        w_a_nan  = (i_a[30:23] == mbda_pkg::EXP_ALL_ONES) && (i_a[22:0] != 23'd0);
        w_b_nan  = (i_b[30:23] == mbda_pkg::EXP_ALL_ONES) && (i_b[22:0] != 23'd0);
        w_a_inf  = (i_a[30:23] == mbda_pkg::EXP_ALL_ONES) && (i_a[22:0] == 23'd0);
        w_b_inf  = (i_b[30:23] == mbda_pkg::EXP_ALL_ONES) && (i_b[22:0] == 23'd0);
        w_a_zero = (i_a[30:0] == 31'd0);
        w_b_zero = (i_b[30:0] == 31'd0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p    <= w_ma * w_mb;
            r_e    <= $signed({3'b0, w_ea}) + $signed({3'b0, w_eb}) - 11'sd127;
            r_sign <= i_a[31] ^ i_b[31];
            r_nan  <= w_a_nan | w_b_nan | (w_a_inf & w_b_zero) | (w_b_inf & w_a_zero);
            r_inf  <= w_a_inf | w_b_inf;
            r_zero <= w_a_zero | w_b_zero;
        end
    end

    logic [5:0]         w_lz;
    logic [47:0]        w_sh;
    logic signed [10:0] w_e;
    logic signed [10:0] w_rs_full;
    logic [6:0]         w_rs;
    logic [71:0]        w_wide;
    logic [7:0]         w_expf;
    logic               w_g, w_st, w_inc;
    logic [30:0]        w_packed;

    always_comb begin
        w_lz = '0;
        for (int i = 0; i < 48; i++) begin
            if (r_p[i]) w_lz = 6'(47 - i);
        end
        w_sh      = r_p << w_lz;
        w_e       = r_e + 11'sd1 - $signed({5'b0, w_lz});
        w_rs_full = 11'sd1 - w_e;
        // below the normal range the significand shifts right into subnormal position
        if (w_e >= 11'sd1)            w_rs = 7'd0;
        else if (w_rs_full > 11'sd63) w_rs = 7'd63;
        else                          w_rs = w_rs_full[6:0];
        w_wide   = {w_sh, 24'd0} >> w_rs;
        w_g      = w_wide[47];
        w_st     = |w_wide[46:0];
        w_inc    = w_g & (w_st | w_wide[48]);
        w_expf   = (w_e < 11'sd1) ? 8'd0 : w_e[7:0];
        w_packed = {w_expf, w_wide[70:48]} + {30'd0, w_inc};

        if (r_nan)                o_y = mbda_pkg::FP32_CANON_NAN;
        else if (r_inf)           o_y = {r_sign, mbda_pkg::EXP_ALL_ONES, 23'd0};
        else if (r_zero)          o_y = {r_sign, 31'd0};
        else if (w_e > 11'sd254)  o_y = {r_sign, mbda_pkg::EXP_ALL_ONES, 23'd0};
        else                      o_y = {r_sign, w_packed};
    end

endmodule

[hw/rtl/mbda_fadd.sv]
// two-stage fp32 adder, round to nearest even, subnormals kept
// stage one aligns and adds, stage two normalizes and rounds
module mbda_fadd (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_y
);

    logic [31:0] w_big, w_small;
    logic [7:0]  w_eb, w_es, w_d;
    logic [4:0]  w_dcap;
    logic [26:0] w_mb_x, w_ms_x, w_small_x;
    logic [53:0] w_align;
    logic        w_a_nan, w_b_nan, w_a_inf, w_b_inf, w_sub;

    logic [27:0] r_sum;
    logic [7:0]  r_exp;
    logic        r_sign, r_sub, r_nan, r_inf, r_inf_sign;

    always_comb begin
        w_a_nan = (i_a[30:23] == mbda_pkg::EXP_ALL_ONES) && (i_a[22:0] != 23'd0);
        w_b_nan = (i_b[30:23] == mbda_pkg::EXP_ALL_ONES) && (i_b[22:0] != 23'd0);
        w_a_inf = (i_a[30:23] == mbda_pkg::EXP_ALL_ONES) && (i_a[22:0] == 23'd0);
        w_b_inf = (i_b[30:23] == mbda_pkg::EXP_ALL_ONES) && (i_b[22:0] == 23'd0);
        if (i_b[30:0] > i_a[30:0]) begin
            w_big   = i_b;
            w_small = i_a;
        end else begin
            w_big   = i_a;
            w_small = i_b;
        end
        w_eb      = (w_big[30:23] == 8'd0) ? 8'd1 : w_big[30:23];
        w_es      = (w_small[30:23] == 8'd0) ? 8'd1 : w_small[30:23];
        w_d       = w_eb - w_es;
        w_dcap    = (w_d > 8'd27) ? 5'd27 : w_d[4:0];
        w_mb_x    = {|w_big[30:23], w_big[22:0], 3'b0};
        w_ms_x    = {|w_small[30:23], w_small[22:0], 3'b0};
        w_align   = {w_ms_x, 27'd0} >> w_dcap;
        // shifted-out bits fold into the sticky position
        w_small_x = {w_align[53:28], w_align[27] | (|w_align[26:0])};
        w_sub     = w_big[31] ^ w_small[31];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum      <= w_sub ? ({1'b0, w_mb_x} - {1'b0, w_small_x})
                                : ({1'b0, w_mb_x} + {1'b0, w_small_x});
            r_exp      <= w_eb;
            r_sign     <= w_big[31];
            r_sub      <= w_sub;
            r_nan      <= w_a_nan | w_b_nan | (w_a_inf & w_b_inf & (i_a[31] ^ i_b[31]));
            r_inf      <= w_a_inf | w_b_inf;
            r_inf_sign <= w_a_inf ? i_a[31] : i_b[31];
        end
    end

    logic [4:0]  w_lz, w_shl;
    logic [7:0]  w_lim;
    logic [26:0] w_n;
    logic [8:0]  w_e;
    logic [7:0]  w_expf;
    logic        w_inc;
    logic [30:0] w_packed;

    always_comb begin
        w_lz = '0;
        for (int i = 0; i < 27; i++) begin
            if (r_sum[i]) w_lz = 5'(26 - i);
        end
        w_lim = r_exp - 8'd1;
        w_shl = ({3'b0, w_lz} > w_lim) ? w_lim[4:0] : w_lz;
        if (r_sum[27]) begin
            w_n = {r_sum[27:2], r_sum[1] | r_sum[0]};
            w_e = {1'b0, r_exp} + 9'd1;
        end else begin
            // left shift stops at the subnormal boundary
            w_n = r_sum[26:0] << w_shl;
            w_e = {1'b0, r_exp} - {4'b0, w_shl};
        end
        w_inc    = w_n[2] & (w_n[1] | w_n[0] | w_n[3]);
        w_expf   = w_n[26] ? w_e[7:0] : 8'd0;
        w_packed = {w_expf, w_n[25:3]} + {30'd0, w_inc};

        if (r_nan)                 o_y = mbda_pkg::FP32_CANON_NAN;
        else if (r_inf)            o_y = {r_inf_sign, mbda_pkg::EXP_ALL_ONES, 23'd0};
        else if (r_sum == 28'd0)   o_y = r_sub ? mbda_pkg::FP32_ZERO : {r_sign, 31'd0};
        else if (w_e >= 9'd255)    o_y = {r_sign, mbda_pkg::EXP_ALL_ONES, 23'd0};
        else                       o_y = {r_sign, w_packed};
    end

endmodule

[hw/rtl/mxfp4_block_dot_accumulate.sv]
// mxfp4 block dot product with fp32 row accumulation, top level
// uses mbda_pkg, mbda_lane, mbda_fmul, mbda_fadd and the defines header
//
// usage:
// the input channel (i_in_valid / o_in_stall) takes one 32-column block of a
// weight row per request: 16 e2m1 code bytes, 32 int8 activations, the ue8m0
// block exponent, the fp32 activation scale and a row_end flag.
// four lanes form exact partial dot products at accept; a merge stage sums them.
// one shared two-stage fp32 multiplier then forms the block scale, halves it
// and scales the dot product; a two-stage fp32 adder adds it to the row sum.
// after accept an item runs through 8 sequencer steps (three passes through the
// multiplier and one through the adder), and the input stalls from each accepted
// request until the sequencer is back in idle, later while an item waits on the output.
// when row_end is set, the row sum is loaded into the output register as the last
// sequencer step completes, shown on o_out_valid / o_row_sum_bits, and the sum clears.
// a stalled result holds; a new block is taken meanwhile, and an item that
// reaches the last step while the output is still occupied waits there until it frees.
// reset clears the row sum to +0.0, drops o_out_valid and returns to idle.
`include "mxfp4_block_dot_accumulate_defines.svh"

module mxfp4_block_dot_accumulate (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [63:0] i_weight_codes_low,
    input  logic [63:0] i_weight_codes_high,
    input  logic [63:0] i_acts_cols_0_7,
    input  logic [63:0] i_acts_cols_8_15,
    input  logic [63:0] i_acts_cols_16_23,
    input  logic [63:0] i_acts_cols_24_31,
    input  logic [7:0]  i_weight_scale_exp,
    input  logic [31:0] i_act_scale_bits,
    input  logic        i_row_end,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_row_sum_bits
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_SCL  = 9'b000000010,
        S_W1   = 9'b000000100,
        S_HALF = 9'b000001000,
        S_W2   = 9'b000010000,
        S_PRD  = 9'b000100000,
        S_W3   = 9'b001000000,
        S_ACC  = 9'b010000000,
        S_W4   = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic [31:0] r_ws, r_as, r_dotf, r_y, r_acc, r_out_bits;
    logic        r_row_end, r_out_valid;
    logic signed [mbda_pkg::DOT_W-1:0] r_dot;

    logic w_accept, w_out_free, w_finish;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_finish   = (r_state == S_W4) && w_out_free;
    assign o_in_stall = (r_state != S_IDLE);

    // lanes
    logic [127:0] w_codes;
    logic [255:0] w_acts;
    logic signed [mbda_pkg::LANE_SUM_W-1:0] w_part [mbda_pkg::LANES];
    logic signed [mbda_pkg::LANE_SUM_W-1:0] r_part [mbda_pkg::LANES];

    assign w_codes = {i_weight_codes_high, i_weight_codes_low};
    assign w_acts  = {i_acts_cols_24_31, i_acts_cols_16_23, i_acts_cols_8_15, i_acts_cols_0_7};

    for (genvar l = 0; l < mbda_pkg::LANES; l++) begin : g_lane
        mbda_lane u_lane (
            .i_codes (w_codes[l*32 +: 32]),
            .i_acts  (w_acts[l*64 +: 64]),
            .o_sum   (w_part[l])
        );
    end

    function automatic logic [31:0] int_to_fp32(input logic signed [mbda_pkg::DOT_W-1:0] v);
        logic [mbda_pkg::DOT_W-1:0] mag;
        logic [mbda_pkg::DOT_W-1:0] nrm;
        logic [4:0]                 lz;
        logic [7:0]                 ex;
        mag = v[mbda_pkg::DOT_W-1] ? mbda_pkg::DOT_W'(-v) : mbda_pkg::DOT_W'(v);
        lz  = '0;
        for (int i = 0; i < mbda_pkg::DOT_W; i++) begin
            if (mag[i]) lz = 5'(mbda_pkg::DOT_W - 1 - i);
        end
        nrm = mag << lz;
        ex  = 8'(127 + mbda_pkg::DOT_W - 1) - {3'b0, lz};
        if (mag == '0) return mbda_pkg::FP32_ZERO;
        return {v[mbda_pkg::DOT_W-1], ex, nrm[mbda_pkg::DOT_W-2:0], 7'd0};
    endfunction

    // shared multiplier
    logic        w_mul_en;
    logic [31:0] w_mul_a, w_mul_b, w_mul_y, w_add_y;

    always_comb begin
        w_mul_en = 1'b1;
        case (r_state)
            S_SCL: begin
                w_mul_a = r_ws;
                w_mul_b = r_as;
            end
            S_HALF: begin
                w_mul_a = r_y;
                w_mul_b = mbda_pkg::FP32_HALF;
            end
            S_PRD: begin
                w_mul_a = r_dotf;
                w_mul_b = r_y;
            end
            default: begin
                w_mul_en = 1'b0;
                w_mul_a  = r_y;
                w_mul_b  = r_y;
            end
        endcase
    end

    mbda_fmul u_fmul (
        .i_clk (i_clk),
        .i_en  (w_mul_en),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_y   (w_mul_y)
    );

    mbda_fadd u_fadd (
        .i_clk (i_clk),
        .i_en  (r_state == S_ACC),
        .i_a   (r_acc),
        .i_b   (r_y),
        .o_y   (w_add_y)
    );

    always_comb begin
        case (r_state)
            S_IDLE:  n_state = w_accept ? S_SCL : S_IDLE;
            S_SCL:   n_state = S_W1;
            S_W1:    n_state = S_HALF;
            S_HALF:  n_state = S_W2;
            S_W2:    n_state = S_PRD;
            S_PRD:   n_state = S_W3;
            S_W3:    n_state = S_ACC;
            S_ACC:   n_state = S_W4;
            S_W4:    n_state = w_out_free ? S_IDLE : S_W4;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_acc       <= mbda_pkg::FP32_ZERO;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= (w_finish && r_row_end) || (r_out_valid && i_out_stall);
            if (w_finish) begin
                if (r_row_end) begin
                    r_acc <= mbda_pkg::FP32_ZERO;
                end else begin
                    r_acc <= w_add_y;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_y <= w_mul_y;
        if (w_accept) begin
            for (int l = 0; l < mbda_pkg::LANES; l++) r_part[l] <= w_part[l];
            r_as      <= i_act_scale_bits;
            r_row_end <= i_row_end;
            if (i_weight_scale_exp == 8'd0)
                r_ws <= mbda_pkg::FP32_MIN_SCALE;
            else if (i_weight_scale_exp == mbda_pkg::EXP_ALL_ONES)
                r_ws <= mbda_pkg::FP32_CANON_NAN;
            else
                r_ws <= {1'b0, i_weight_scale_exp, 23'd0};
        end
        // merge the lane partials, then convert
        if (r_state == S_SCL) begin
            r_dot <= mbda_pkg::DOT_W'(r_part[0]) + mbda_pkg::DOT_W'(r_part[1])
                   + mbda_pkg::DOT_W'(r_part[2]) + mbda_pkg::DOT_W'(r_part[3]);
        end
        if (r_state == S_W1) r_dotf <= int_to_fp32(r_dot);
        if (w_finish && r_row_end) r_out_bits <= w_add_y;
    end

    assign o_out_valid    = r_out_valid;
    assign o_row_sum_bits = r_out_bits;

    `MBDA_ASSERT_NEXT(a_row_end_clears, w_finish && r_row_end, r_acc == mbda_pkg::FP32_ZERO)
    `MBDA_ASSERT_SAME(a_out_from_finish, $rose(o_out_valid), $past(w_finish) && $past(r_row_end))
    `MBDA_ASSERT_NEXT(a_no_out_mid_row, w_finish && !r_row_end, !$rose(o_out_valid))

endmodule

[tb/sv/testbench.sv]
// self-checking testbench for mxfp4_block_dot_accumulate
// depends on mbda_pkg and the block's rtl; carries its own bit-exact fp32 row-sum model
module testbench;

    localparam int CLK_HALF      = 6;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int DRAIN_WAIT    = 24;
    localparam int IDLE_PCT_ONE  = 68;
    localparam int IDLE_PCT_BOTH = 31;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [63:0] i_weight_codes_low;
    logic [63:0] i_weight_codes_high;
    logic [63:0] i_acts_cols_0_7;
    logic [63:0] i_acts_cols_8_15;
    logic [63:0] i_acts_cols_16_23;
    logic [63:0] i_acts_cols_24_31;
    logic [7:0]  i_weight_scale_exp;
    logic [31:0] i_act_scale_bits;
    logic        i_row_end;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_row_sum_bits;

    mxfp4_block_dot_accumulate u_dut (.*);

    logic [31:0] row_sum_model;
    logic [31:0] expected_sums[$];
    t_idle_mode  idle_mode;
    int          mismatches = 0;
    int          cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int idle_percent();
        return (idle_mode == IDLE_BOTH) ? IDLE_PCT_BOTH : IDLE_PCT_ONE;
    endfunction

    always @(posedge i_clk) begin
        if (idle_mode == IDLE_RECV || idle_mode == IDLE_BOTH)
            i_out_stall <= ($urandom_range(99) < idle_percent());
        else
            i_out_stall <= 1'b0;
    end

    // fp32 helpers: value = mag * 2^e, rounded to nearest even, subnormals kept
    function automatic logic [31:0] fp32_round(bit sgn, logic [127:0] mag, int e);
        int p;
        int sh;
        int le;
        logic [127:0] q;
        bit g;
        bit st;
        if (mag == 0) return {sgn, 31'd0};
        p = 127;
        while (!mag[p]) p--;
        sh = p - 23;
        if (sh < -149 - e) sh = -149 - e;
        if (sh > p + 1) return {sgn, 31'd0};
        if (sh > 0) begin
            q  = mag >> sh;
            g  = mag[sh-1];
            st = ((mag & ((128'd1 << (sh - 1)) - 1)) != 0);
            if (g && (st || q[0])) q = q + 1;
        end else begin
            q = mag << (-sh);
        end
        le = e + sh;
        if (q[24]) begin
            q  = q >> 1;
            le = le + 1;
        end
        if (q == 0) return {sgn, 31'd0};
        if (!q[23]) return {sgn, 8'd0, q[22:0]};
        if (le + 150 >= 255) return {sgn, 8'hFF, 23'd0};
        return {sgn, 8'(le + 150), q[22:0]};
    endfunction

    function automatic void fp32_unpack(logic [31:0] x, output logic [23:0] m, output int e);
        if (x[30:23] == 0) begin
            m = {1'b0, x[22:0]};
            e = -149;
        end else begin
            m = {1'b1, x[22:0]};
            e = int'(x[30:23]) - 150;
        end
    endfunction

    function automatic bit fp32_is_nan(logic [31:0] x);
        return x[30:23] == 8'hFF && x[22:0] != 0;
    endfunction

    function automatic bit fp32_is_inf(logic [31:0] x);
        return x[30:23] == 8'hFF && x[22:0] == 0;
    endfunction

    function automatic logic [31:0] fp32_mul(logic [31:0] a, logic [31:0] b);
        logic [23:0] ma;
        logic [23:0] mb;
        int ea;
        int eb;
        bit s;
        bit za;
        bit zb;
        s  = a[31] ^ b[31];
        za = (a[30:0] == 0);
        zb = (b[30:0] == 0);
        if (fp32_is_nan(a) || fp32_is_nan(b) || (fp32_is_inf(a) && zb) || (za && fp32_is_inf(b)))
            return mbda_pkg::FP32_CANON_NAN;
        if (fp32_is_inf(a) || fp32_is_inf(b)) return {s, 8'hFF, 23'd0};
        if (za || zb) return {s, 31'd0};
        fp32_unpack(a, ma, ea);
        fp32_unpack(b, mb, eb);
        return fp32_round(s, 128'(ma) * 128'(mb), ea + eb);
    endfunction

    function automatic logic [31:0] fp32_add(logic [31:0] a, logic [31:0] b);
        logic [23:0] ma;
        logic [23:0] mb;
        logic [31:0] t;
        logic [127:0] big;
        logic [127:0] lit;
        int ea;
        int eb;
        int e;
        if (fp32_is_nan(a) || fp32_is_nan(b)) return mbda_pkg::FP32_CANON_NAN;
        if (fp32_is_inf(a) && fp32_is_inf(b))
            return (a[31] != b[31]) ? mbda_pkg::FP32_CANON_NAN : a;
        if (fp32_is_inf(a)) return a;
        if (fp32_is_inf(b)) return b;
        if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'd0};
        if (a[30:0] == 0) return b;
        if (b[30:0] == 0) return a;
        fp32_unpack(a, ma, ea);
        fp32_unpack(b, mb, eb);
        if (eb > ea) begin
            t = a; a = b; b = t;
            fp32_unpack(a, ma, ea);
            fp32_unpack(b, mb, eb);
        end
        if (ea - eb <= 100) begin
            big = 128'(ma) << (ea - eb);
            lit = 128'(mb);
            e   = eb;
        end else begin
            // far smaller addend only matters as a sticky bit
            big = 128'(ma) << 30;
            lit = 128'd1;
            e   = ea - 30;
        end
        if (a[31] == b[31]) return fp32_round(a[31], big + lit, e);
        if (big == lit) return mbda_pkg::FP32_ZERO;
        if (big > lit) return fp32_round(a[31], big - lit, e);
        return fp32_round(b[31], lit - big, e);
    endfunction

    // one block into the running row sum; returns 1 with the finished sum at row end
    function automatic bit accumulate_block(logic [127:0] codes, logic [255:0] acts,
                                            logic [7:0] wexp, logic [31:0] ascale,
                                            bit row_end, output logic [31:0] sum_out);
        int mag_tab[8] = '{0, 1, 2, 3, 4, 6, 8, 12};
        int dot;
        int w;
        logic [3:0] code;
        logic [31:0] wscale;
        logic [31:0] scale;
        logic [31:0] dot_f;
        dot = 0;
        for (int c = 0; c < 32; c++) begin
            code = codes[c*4 +: 4];
            w = code[3] ? -mag_tab[code[2:0]] : mag_tab[code[2:0]];
            dot += w * int'($signed(acts[c*8 +: 8]));
        end
        if (wexp == 0) wscale = mbda_pkg::FP32_MIN_SCALE;
        else if (wexp == mbda_pkg::EXP_ALL_ONES) wscale = mbda_pkg::FP32_CANON_NAN;
        else wscale = {1'b0, wexp, 23'd0};
        scale = fp32_mul(fp32_mul(wscale, ascale), mbda_pkg::FP32_HALF);
        dot_f = fp32_round(dot < 0, 128'(dot < 0 ? -dot : dot), 0);
        row_sum_model = fp32_add(row_sum_model, fp32_mul(dot_f, scale));
        sum_out = fp32_is_nan(row_sum_model) ? mbda_pkg::FP32_CANON_NAN : row_sum_model;
        if (row_end) row_sum_model = mbda_pkg::FP32_ZERO;
        return row_end;
    endfunction

    task automatic send_block(logic [127:0] codes, logic [255:0] acts, logic [7:0] wexp,
                              logic [31:0] ascale, bit row_end);
        logic [31:0] sum;
        if (idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH) begin
            while ($urandom_range(99) < idle_percent()) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid          <= 1'b1;
        i_weight_codes_low  <= codes[63:0];
        i_weight_codes_high <= codes[127:64];
        i_acts_cols_0_7     <= acts[63:0];
        i_acts_cols_8_15    <= acts[127:64];
        i_acts_cols_16_23   <= acts[191:128];
        i_acts_cols_24_31   <= acts[255:192];
        i_weight_scale_exp  <= wexp;
        i_act_scale_bits    <= ascale;
        i_row_end           <= row_end;
        forever begin
            @(negedge i_clk);
            if (!o_in_stall) break;
        end
        @(posedge i_clk);
        if (accumulate_block(codes, acts, wexp, ascale, row_end, sum))
            expected_sums.push_back(sum);
    endtask

    // each accepted result against the oldest expected row sum
    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_sums.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected row sum %h", o_row_sum_bits);
            end else begin
                if (o_row_sum_bits !== expected_sums[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("row sum mismatch: expected %h actual %h",
                                 expected_sums[0], o_row_sum_bits);
                end
                void'(expected_sums.pop_front());
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [255:0] rand_acts();
        return {rand64(), rand64(), rand64(), rand64()};
    endfunction

    function automatic logic [31:0] rand_act_scale();
        int pick;
        pick = $urandom_range(99);
        if (pick < 85) return {1'($urandom), 8'($urandom_range(100, 150)), 23'($urandom)};
        return $urandom;
    endfunction

    function automatic logic [7:0] rand_weight_exp();
        int pick;
        pick = $urandom_range(99);
        if (pick < 88) return 8'($urandom_range(100, 154));
        if (pick < 92) return 8'd0;
        if (pick < 94) return mbda_pkg::EXP_ALL_ONES;
        return 8'($urandom);
    endfunction

    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        while (expected_sums.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic test_code_table();
        // codes 7 and F against extreme activations, every code against -1, and the zero codes
        send_block({16{8'h77}}, {32{8'h80}}, 8'd127, 32'h3F80_0000, 1'b0);
        send_block({16{8'hFF}}, {32{8'h7F}}, 8'd127, 32'h3F80_0000, 1'b1);
        send_block(128'h0123_4567_89AB_CDEF_FEDC_BA98_7654_3210, {32{8'hFF}},
                   8'd130, 32'h3F80_0000, 1'b1);
        send_block(128'h0, {32{8'h7F}}, 8'd127, 32'h3F80_0000, 1'b1);
        send_block({32{4'h8}}, rand_acts(), 8'd127, 32'hBF80_0000, 1'b1);
        send_block({16{8'hFF}}, {32{8'h80}}, 8'd127, 32'h3F80_0000, 1'b0);
        send_block({16{8'h77}}, {32{8'h80}}, 8'd127, 32'h3F80_0000, 1'b1);
    endtask

    task automatic test_exponent_extremes();
        send_block({16{8'h11}}, {32{8'h01}}, 8'd0, 32'h3F80_0000, 1'b1);
        send_block({16{8'h77}}, {32{8'h7F}}, 8'd0, 32'h0000_0001, 1'b1);
        send_block(rand64() + 128'd1, rand_acts(), mbda_pkg::EXP_ALL_ONES, 32'h3F80_0000, 1'b1);
        send_block({16{8'h77}}, {32{8'h7F}}, 8'd254, 32'h7F7F_FFFF, 1'b1);
        send_block({16{8'hFF}}, {32{8'h7F}}, 8'd254, 32'h7F00_0000, 1'b0);
        send_block({16{8'hFF}}, {32{8'h7F}}, 8'd254, 32'h7F00_0000, 1'b1);
        send_block({16{8'h77}}, {32{8'h7F}}, 8'd200, 32'h7000_0000, 1'b0);
        send_block({16{8'hFF}}, {32{8'h7F}}, 8'd200, 32'h7000_0000, 1'b1);
    endtask

    task automatic test_special_scales();
        send_block({16{8'h22}}, {32{8'h05}}, 8'd127, 32'h7F80_0000, 1'b1);
        send_block({16{8'h22}}, {32{8'h05}}, 8'd127, 32'hFF80_0000, 1'b1);
        send_block(128'h0, {32{8'h05}}, 8'd127, 32'h7F80_0000, 1'b1);
        send_block({16{8'h22}}, {32{8'h05}}, 8'd127, 32'hFFC1_2345, 1'b1);
        send_block({16{8'h22}}, {32{8'h05}}, 8'd127, 32'h7F80_0000, 1'b0);
        send_block({16{8'hAA}}, {32{8'h05}}, 8'd127, 32'h7F80_0000, 1'b1);
        send_block({16{8'h22}}, {32{8'h05}}, 8'd127, 32'h8000_0000, 1'b1);
    endtask

    task automatic test_random_rows(int blocks, t_idle_mode mode);
        idle_mode = mode;
        for (int n = 0; n < blocks; n++)
            send_block({rand64(), rand64()}, rand_acts(), rand_weight_exp(),
                       rand_act_scale(), $urandom_range(3) == 0);
        wait_for_drain();
    endtask

    initial begin
        idle_mode           = IDLE_NONE;
        row_sum_model       = mbda_pkg::FP32_ZERO;
        i_rst_n             <= 1'b0;
        i_in_valid          <= 1'b0;
        i_weight_codes_low  <= '0;
        i_weight_codes_high <= '0;
        i_acts_cols_0_7     <= '0;
        i_acts_cols_8_15    <= '0;
        i_acts_cols_16_23   <= '0;
        i_acts_cols_24_31   <= '0;
        i_weight_scale_exp  <= '0;
        i_act_scale_bits    <= '0;
        i_row_end           <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_code_table();
        test_exponent_extremes();
        test_special_scales();
        wait_for_drain();
        test_random_rows(460, IDLE_NONE);
        test_random_rows(460, IDLE_SEND);
        test_random_rows(460, IDLE_RECV);
        test_random_rows(460, IDLE_BOTH);

        if (mismatches == 0 && expected_sums.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/mbda_pkg.sv
hw/rtl/mbda_lane.sv
hw/rtl/mbda_fmul.sv
hw/rtl/mbda_fadd.sv
hw/rtl/mxfp4_block_dot_accumulate.sv
tb/sv/testbench.sv
